// File: design/positional_list_engine_top_assert.svh
// assertion macros used by the checker file
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define PLE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define PLE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ple_pkg.sv
package ple_pkg;

   localparam int CmdW   = 3;
   localparam int PosW   = 5;
   localparam int ValueW = 32;
   localparam int StatW  = 2;

   typedef enum logic [CmdW-1:0] {
      CMD_GET    = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_LOCATE = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   localparam logic [StatW-1:0] ST_OK       = 2'd0;
   localparam logic [StatW-1:0] ST_ERR      = 2'd1;
   localparam logic [StatW-1:0] ST_NOTFOUND = 2'd2;

   // command presented to the list store
   typedef struct packed {
      logic              fire;
      cmd_type           cmd;
      logic [PosW-1:0]   position;
      logic [ValueW-1:0] value;
   } ple_op_type;

   // result computed by the list store
   typedef struct packed {
      logic [StatW-1:0]  status;
      logic [ValueW-1:0] element;
      logic [PosW-1:0]   found_position;
      logic [PosW-1:0]   length;
      logic              empty_res;
   } ple_res_type;

endpackage

// File: design/positional_list_engine_top.sv
// an accepted request passes through the input stage and then the response stage before its response shows on rsp_valid
// throughput: one transaction per cycle, sustained while the response side takes them
// each command is decoded and applied to all list cells in parallel
// reset (synchronous, active high) empties the list and drops both pipeline stages
// element storage is not cleared; entries past the length are never read
module positional_list_engine_top #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic [4:0]         req_position,
   input  logic signed [31:0] req_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_element,
   output logic [4:0]         rsp_found_position,
   output logic [4:0]         rsp_length,
   output logic               rsp_empty_res
);
   import ple_pkg::*;

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   logic [CmdW-1:0]   s1_cmd_ff;
   logic [PosW-1:0]   s1_pos_ff;
   logic [ValueW-1:0] s1_value_ff;

   // response stage
   logic        rsp_valid_ff, rsp_valid_in;
   ple_res_type rsp_ff;

   ple_op_type  op;
   ple_res_type res;
   logic        advance;
   logic        req_fire;

   // the response register frees up when empty or being taken this cycle
   assign advance   = !rsp_valid_ff || rsp_ready;
   // input stage can load when empty or moving into the response stage
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   // list state changes exactly when the command moves into the response stage
   assign op.fire     = s1_valid_ff && advance;
   assign op.cmd      = cmd_type'(s1_cmd_ff);
   assign op.position = s1_pos_ff;
   assign op.value    = s1_value_ff;

   ple_store #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .res   (res)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff   <= req_cmd;
         s1_pos_ff   <= req_position;
         s1_value_ff <= req_value;
      end
      if (op.fire) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_element        = signed'(rsp_ff.element);
   assign rsp_found_position = rsp_ff.found_position;
   assign rsp_length         = rsp_ff.length;
   assign rsp_empty_res      = rsp_ff.empty_res;

endmodule

// File: design/ple_store.sv
module ple_store #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  ple_pkg::ple_op_type op,
   output ple_pkg::ple_res_type res
);
   import ple_pkg::*;

   localparam int StoreW = (DATA_WIDTH < ValueW) ? DATA_WIDTH : ValueW;
   localparam int CntW   = $clog2(CAPACITY + 1);
   localparam int CmpW   = ((CntW > PosW) ? CntW : PosW) + 1;

   logic [StoreW-1:0] elem_ff   [CAPACITY];
   logic [StoreW-1:0] elem_in   [CAPACITY];
   logic [StoreW-1:0] below_src [CAPACITY];
   logic [StoreW-1:0] above_src [CAPACITY];
   logic [CntW-1:0]   count_ff, count_in;

   logic [StoreW-1:0] key;
   logic [StoreW-1:0] rd_data;
   logic [CmpW-1:0]   pos_c, cnt_c, slot_c, found_c;
   logic              pos_in_list, pos_for_ins, do_ins, do_del, do_clr;

   // neighbor taps for the shift up and shift down
   for (genvar g = 0; g < CAPACITY; g++) begin : g_taps
      assign below_src[g] = elem_ff[(g == 0) ? 0 : g - 1];
      assign above_src[g] = elem_ff[(g == CAPACITY - 1) ? g : g + 1];
   end

   assign key         = op.value[StoreW-1:0];
   assign pos_c       = CmpW'(op.position);
   assign cnt_c       = CmpW'(count_ff);
   assign slot_c      = pos_c - CmpW'(1);
   assign pos_in_list = (pos_c != '0) && (pos_c <= cnt_c);
   assign pos_for_ins = (pos_c != '0) && (pos_c <= cnt_c + CmpW'(1))
                        && (cnt_c < CmpW'(CAPACITY));
   assign do_ins      = op.fire && (op.cmd == CMD_INSERT) && pos_for_ins;
   assign do_del      = op.fire && (op.cmd == CMD_DELETE) && pos_in_list;
   assign do_clr      = op.fire && (op.cmd == CMD_CLEAR);

   // one-hot read of the addressed entry
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_data = rd_data | ({StoreW{CmpW'(i) == slot_c}} & elem_ff[i]);
      end
   end

   // lowest matching live entry wins
   always_comb begin
      found_c = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if ((elem_ff[i] == key) && (CmpW'(i) < cnt_c)) begin
            found_c = CmpW'(i + 1);
         end
      end
   end

   // per-cell next value
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         elem_in[i] = elem_ff[i];
         if (do_ins) begin
            if (CmpW'(i) == slot_c) begin
               elem_in[i] = key;
            end else if (CmpW'(i) > slot_c) begin
               elem_in[i] = below_src[i];
            end
         end else if (do_del) begin
            if (CmpW'(i) >= slot_c) begin
               elem_in[i] = above_src[i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CntW'(1);
      end else if (do_del) begin
         count_in = count_ff - CntW'(1);
      end else if (do_clr) begin
         count_in = '0;
      end
   end

   always_comb begin
      res.status         = ST_OK;
      res.element        = '0;
      res.found_position = '0;
      case (op.cmd)
         CMD_GET: begin
            if (pos_in_list) begin
               res.element = ValueW'(rd_data);
            end else begin
               res.status = ST_ERR;
            end
         end
         CMD_INSERT: begin
            if (!pos_for_ins) begin
               res.status = ST_ERR;
            end
         end
         CMD_DELETE: begin
            if (pos_in_list) begin
               res.element = ValueW'(rd_data);
            end else begin
               res.status = ST_ERR;
            end
         end
         CMD_LOCATE: begin
            if (found_c != '0) begin
               res.found_position = PosW'(found_c);
            end else begin
               res.status = ST_NOTFOUND;
            end
         end
         CMD_CLEAR: begin
            res.status = ST_OK;
         end
         default: begin
            res.status = ST_ERR;
         end
      endcase
      res.length    = PosW'(count_in);
      res.empty_res = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         elem_ff[i] <= elem_in[i];
      end
   end

endmodule

// File: design/ple_checker.sv
module ple_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_element,
   input logic [4:0]         rsp_found_position,
   input logic [4:0]         rsp_length,
   input logic               rsp_empty_res
);
   import ple_pkg::*;

`include "positional_list_engine_top_assert.svh"

   `PLE_ASSERT_IMP(a_empty_matches_length, clock, reset, rsp_valid, rsp_empty_res == (rsp_length == 5'd0), "empty flag disagrees with length")

   `PLE_ASSERT_IMP(a_status_code_legal, clock, reset, rsp_valid, (rsp_status == ST_OK) || (rsp_status == ST_ERR) || (rsp_status == ST_NOTFOUND), "illegal status code")

   `PLE_ASSERT_IMP(a_error_clean, clock, reset, rsp_valid && (rsp_status != ST_OK), (rsp_element == 32'sd0) && (rsp_found_position == 5'd0), "error response carries data")

   `PLE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_element) && $stable(rsp_length), "stalled response changed")

   // the request side only backs up behind a stalled response
   `PLE_ASSERT_IMP(a_req_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready, "request stalled without a held response")

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_element        (rsp_element),
   .rsp_found_position (rsp_found_position),
   .rsp_length         (rsp_length),
   .rsp_empty_res      (rsp_empty_res)
);
